/* rtl/vau_pkg.sv */
`default_nettype none
package vau_pkg;

    localparam int COORDS      = 4;
    localparam int DIM_W       = 3;
    localparam int COORD_W     = 16;
    localparam int DOT_W       = 34;
    localparam int SUMSQ_W     = 33;
    localparam int NORM_W      = 17;
    localparam int DEN_W       = 33;
    localparam int QUO_W       = 32;
    localparam int COS_W       = 31;
    localparam int SIN_W       = 31;
    localparam int CORDIC_W    = 33;
    localparam int ZACC_W      = 24;
    localparam int THETA_W     = 26;
    localparam int ANGLE_W     = 16;
    localparam int CORDIC_STEPS = 20;
    localparam logic [COS_W-1:0]   ONE_Q30    = COS_W'(1) << 30;
    localparam logic [THETA_W-1:0] DEG180_Q16 = THETA_W'(180 * 65536);
    localparam logic [17:0]        ANGLE_MAX  = 18'd46080;

    // state that rides along with the cosine through divide, sqrt and cordic
    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic [NORM_W-1:0]       norm_a;
        logic [NORM_W-1:0]       norm_b;
        logic                    dims_differ;
        logic                    zero_norm;
        logic                    neg;
    } item_side_t;

    localparam int SIDE_W = $bits(item_side_t);

    // arctangent of 2^-i in degrees, Q16.16
    function automatic logic [ZACC_W-1:0] atan_deg(input int i);
        logic [ZACC_W-1:0] r;
        case (i)
            0:       r = ZACC_W'(2949120);
            1:       r = ZACC_W'(1740967);
            2:       r = ZACC_W'(919879);
            3:       r = ZACC_W'(466945);
            4:       r = ZACC_W'(234379);
            5:       r = ZACC_W'(117304);
            6:       r = ZACC_W'(58666);
            7:       r = ZACC_W'(29335);
            8:       r = ZACC_W'(14668);
            9:       r = ZACC_W'(7334);
            10:      r = ZACC_W'(3667);
            11:      r = ZACC_W'(1833);
            12:      r = ZACC_W'(917);
            13:      r = ZACC_W'(458);
            14:      r = ZACC_W'(229);
            15:      r = ZACC_W'(115);
            16:      r = ZACC_W'(57);
            17:      r = ZACC_W'(29);
            18:      r = ZACC_W'(14);
            19:      r = ZACC_W'(7);
            default: r = '0;
        endcase
        return r;
    endfunction

    // arithmetic shift that rounds toward zero
    function automatic logic signed [CORDIC_W-1:0] shr_tz(
        input logic signed [CORDIC_W-1:0] v, input int s);
        logic signed [CORDIC_W-1:0] m;
        m = v[CORDIC_W-1] ? -v : v;
        m = m >>> s;
        return v[CORDIC_W-1] ? -m : m;
    endfunction

endpackage
`default_nettype wire

/* rtl/vau_isqrt.sv */
`default_nettype none
module vau_isqrt import vau_pkg::*; #(
    parameter int IN_W   = 34,
    parameter int SIDE_IN_W = 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic                  in_vld,
    input  wire logic [IN_W-1:0]       radicand,
    input  wire logic [SIDE_IN_W-1:0]  side_in,
    output logic                       out_vld,
    output logic [IN_W/2-1:0]          root,
    output logic [SIDE_IN_W-1:0]       side_out
);
    localparam int OUT_W = IN_W / 2;
    localparam int RW    = OUT_W + 3;

    logic             vld_reg  [OUT_W];
    logic [RW-1:0]    rem_reg  [OUT_W];
    logic [OUT_W-1:0] root_reg [OUT_W];
    logic [IN_W-1:0]  v_reg    [OUT_W];
    logic [SIDE_IN_W-1:0] side_reg [OUT_W];

    // one result bit per stage, most significant pair first
    for (genvar s = 0; s < OUT_W; s++) begin : g_stage
        localparam int P = OUT_W - 1 - s;
        logic             vld_in;
        logic [RW-1:0]    rem_in;
        logic [OUT_W-1:0] root_in;
        logic [IN_W-1:0]  v_in;
        logic [SIDE_IN_W-1:0] side_stage;
        logic [RW-1:0]    rem_sh;
        logic [RW-1:0]    trial;
        logic             ge;

        if (s == 0) begin : g_first
            assign vld_in     = in_vld;
            assign rem_in     = '0;
            assign root_in    = '0;
            assign v_in       = radicand;
            assign side_stage = side_in;
        end
        else begin : g_rest
            assign vld_in     = vld_reg[s-1];
            assign rem_in     = rem_reg[s-1];
            assign root_in    = root_reg[s-1];
            assign v_in       = v_reg[s-1];
            assign side_stage = side_reg[s-1];
        end

        assign rem_sh = {rem_in[RW-4:0], v_in[2*P+1 -: 2]};
        assign trial  = {1'b0, root_in, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                vld_reg[s] <= 1'b0;
            end
            else if (en) begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                rem_reg[s]  <= ge ? rem_sh - trial : rem_sh;
                root_reg[s] <= {root_in[OUT_W-2:0], ge};
                v_reg[s]    <= v_in;
                side_reg[s] <= side_stage;
            end
        end
    end

    assign out_vld  = vld_reg[OUT_W-1];
    assign root     = root_reg[OUT_W-1];
    assign side_out = side_reg[OUT_W-1];
endmodule
`default_nettype wire

/* rtl/vau_div.sv */
`default_nettype none
module vau_div import vau_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_vld,
    input  wire logic [DEN_W-1:0]   mag,
    input  wire logic [DEN_W-1:0]   den,
    input  wire item_side_t         side_in,
    output logic                    out_vld,
    output logic [QUO_W-1:0]        quo,
    output item_side_t              side_out
);
    // quotient of mag * 2^30 / den; mag < 4 * den keeps it within 32 bits
    logic             vld_reg  [QUO_W];
    logic [DEN_W-1:0] rem_reg  [QUO_W];
    logic [QUO_W-1:0] quo_reg  [QUO_W];
    logic [DEN_W-1:0] den_reg  [QUO_W];
    logic [1:0]       lo_reg   [QUO_W];
    item_side_t       side_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic             vld_in;
        logic [DEN_W-1:0] rem_in;
        logic [QUO_W-1:0] quo_in;
        logic [DEN_W-1:0] den_in;
        logic [1:0]       lo_in;
        item_side_t       side_stage;
        logic             nbit;
        logic [DEN_W:0]   sh;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (k == 0) begin : g_first
            assign vld_in     = in_vld;
            assign rem_in     = {2'b00, mag[DEN_W-1:2]};
            assign quo_in     = '0;
            assign den_in     = den;
            assign lo_in      = mag[1:0];
            assign side_stage = side_in;
        end
        else begin : g_rest
            assign vld_in     = vld_reg[k-1];
            assign rem_in     = rem_reg[k-1];
            assign quo_in     = quo_reg[k-1];
            assign den_in     = den_reg[k-1];
            assign lo_in      = lo_reg[k-1];
            assign side_stage = side_reg[k-1];
        end

        if (k == 0) begin : g_b1
            assign nbit = lo_in[1];
        end
        else if (k == 1) begin : g_b0
            assign nbit = lo_in[0];
        end
        else begin : g_bz
            assign nbit = 1'b0;
        end

        assign sh   = {rem_in, nbit};
        assign diff = sh - {1'b0, den_in};
        assign ge   = sh >= {1'b0, den_in};

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                vld_reg[k] <= 1'b0;
            end
            else if (en) begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                rem_reg[k]  <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
                quo_reg[k]  <= {quo_in[QUO_W-2:0], ge};
                den_reg[k]  <= den_in;
                lo_reg[k]   <= lo_in;
                side_reg[k] <= side_stage;
            end
        end
    end

    assign out_vld  = vld_reg[QUO_W-1];
    assign quo      = quo_reg[QUO_W-1];
    assign side_out = side_reg[QUO_W-1];
endmodule
`default_nettype wire

/* rtl/vau_cordic.sv */
`default_nettype none
module vau_cordic import vau_pkg::*; #(
    parameter int SIDE_IN_W = 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_vld,
    input  wire logic signed [CORDIC_W-1:0]  x_in,
    input  wire logic signed [CORDIC_W-1:0]  y_in,
    input  wire logic [SIDE_IN_W-1:0]        side_in,
    output logic                             out_vld,
    output logic signed [ZACC_W-1:0]         z_out,
    output logic [SIDE_IN_W-1:0]             side_out
);
    logic                       vld_reg  [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] x_reg    [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] y_reg    [CORDIC_STEPS];
    logic signed [ZACC_W-1:0]   z_reg    [CORDIC_STEPS];
    logic [SIDE_IN_W-1:0]       side_reg [CORDIC_STEPS];

    // vectoring mode: rotate y toward zero, accumulate angle in z
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
        logic                       vld_in;
        logic signed [CORDIC_W-1:0] x_s;
        logic signed [CORDIC_W-1:0] y_s;
        logic signed [ZACC_W-1:0]   z_s;
        logic [SIDE_IN_W-1:0]       side_stage;
        logic signed [CORDIC_W-1:0] xs;
        logic signed [CORDIC_W-1:0] ys;
        logic                       up;

        if (i == 0) begin : g_first
            assign vld_in     = in_vld;
            assign x_s        = x_in;
            assign y_s        = y_in;
            assign z_s        = '0;
            assign side_stage = side_in;
        end
        else begin : g_rest
            assign vld_in     = vld_reg[i-1];
            assign x_s        = x_reg[i-1];
            assign y_s        = y_reg[i-1];
            assign z_s        = z_reg[i-1];
            assign side_stage = side_reg[i-1];
        end

        assign xs = shr_tz(x_s, i);
        assign ys = shr_tz(y_s, i);
        assign up = !y_s[CORDIC_W-1];

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                vld_reg[i] <= 1'b0;
            end
            else if (en) begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                x_reg[i]    <= up ? x_s + ys : x_s - ys;
                y_reg[i]    <= up ? y_s - xs : y_s + xs;
                z_reg[i]    <= up ? z_s + signed'(atan_deg(i)) : z_s - signed'(atan_deg(i));
                side_reg[i] <= side_stage;
            end
        end
    end

    assign out_vld  = vld_reg[CORDIC_STEPS-1];
    assign z_out    = z_reg[CORDIC_STEPS-1];
    assign side_out = side_reg[CORDIC_STEPS-1];
endmodule
`default_nettype wire

/* rtl/vector_angle_unit.sv */
// throughput: one vector pair per cycle, the pipeline stalls as a whole while out_valid is high and out_ready low
// stages: products, sums, 17-stage norm sqrt, norm product, 32-stage divider, cosine clamp,
//   square, one minus square, 61-bit sine sqrt in 31 stages, 20 cordic stages, output
// reset: rst_n clears only the stage valid bits, data registers are not reset
`default_nettype none
module vector_angle_unit import vau_pkg::*; #(
    parameter int MAX_COORDS = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [DIM_W-1:0]           dim_a,
    input  wire logic [DIM_W-1:0]           dim_b,
    input  wire logic signed [COORD_W-1:0]  a_0,
    input  wire logic signed [COORD_W-1:0]  a_1,
    input  wire logic signed [COORD_W-1:0]  a_2,
    input  wire logic signed [COORD_W-1:0]  a_3,
    input  wire logic signed [COORD_W-1:0]  b_0,
    input  wire logic signed [COORD_W-1:0]  b_1,
    input  wire logic signed [COORD_W-1:0]  b_2,
    input  wire logic signed [COORD_W-1:0]  b_3,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [DOT_W-1:0]         dot,
    output logic [NORM_W-1:0]               norm_a,
    output logic [NORM_W-1:0]               norm_b,
    output logic [ANGLE_W-1:0]              angle,
    output logic                            dims_differ,
    output logic                            zero_norm
);
    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_COORDS);
    localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(2);
    localparam int SQ_W = 31;
    localparam int PR_W = 32;

    logic en;

    // ---- stage 1: clamp dimensions, products
    logic signed [COORD_W-1:0] av [COORDS];
    logic signed [COORD_W-1:0] bv [COORDS];
    logic [DIM_W-1:0] da, db;
    logic [SQ_W-1:0]        sqa_next [COORDS];
    logic [SQ_W-1:0]        sqb_next [COORDS];
    logic signed [PR_W-1:0] pab_next [COORDS];
    logic [SQ_W-1:0]        sqa_reg  [COORDS];
    logic [SQ_W-1:0]        sqb_reg  [COORDS];
    logic signed [PR_W-1:0] pab_reg  [COORDS];
    logic s1_vld_reg, s1_differ_reg;

    assign av[0] = a_0;
    assign av[1] = a_1;
    assign av[2] = a_2;
    assign av[3] = a_3;
    assign bv[0] = b_0;
    assign bv[1] = b_1;
    assign bv[2] = b_2;
    assign bv[3] = b_3;

    assign da = (dim_a < DIM_MIN) ? DIM_MIN : ((dim_a > DIM_MAX) ? DIM_MAX : dim_a);
    assign db = (dim_b < DIM_MIN) ? DIM_MIN : ((dim_b > DIM_MAX) ? DIM_MAX : dim_b);

    always_comb begin
        logic signed [PR_W-1:0] pa, pb, pp;
        for (int i = 0; i < COORDS; i++) begin
            pa = av[i] * av[i];
            pb = bv[i] * bv[i];
            pp = av[i] * bv[i];
            sqa_next[i] = (DIM_W'(i) < da) ? pa[SQ_W-1:0] : '0;
            sqb_next[i] = (DIM_W'(i) < db) ? pb[SQ_W-1:0] : '0;
            pab_next[i] = (DIM_W'(i) < da) ? pp : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_vld_reg <= 1'b0;
        end
        else if (en) begin
            s1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            sqa_reg       <= sqa_next;
            sqb_reg       <= sqb_next;
            pab_reg       <= pab_next;
            s1_differ_reg <= da != db;
        end
    end

    // ---- stage 2: sums
    logic [SUMSQ_W-1:0]      sa_next, sb_next, sa_reg, sb_reg;
    logic signed [DOT_W-1:0] dsum_next, dot2_reg;
    logic s2_vld_reg, s2_differ_reg;

    always_comb begin
        sa_next   = '0;
        sb_next   = '0;
        dsum_next = '0;
        for (int i = 0; i < COORDS; i++) begin
            sa_next   = sa_next + SUMSQ_W'(sqa_reg[i]);
            sb_next   = sb_next + SUMSQ_W'(sqb_reg[i]);
            dsum_next = dsum_next + DOT_W'(pab_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s2_vld_reg <= 1'b0;
        end
        else if (en) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            sa_reg        <= sa_next;
            sb_reg        <= sb_next;
            dot2_reg      <= s1_differ_reg ? '0 : dsum_next;
            s2_differ_reg <= s1_differ_reg;
        end
    end

    // ---- norms
    logic na_vld, nb_vld;
    logic [NORM_W-1:0] na, nb;
    logic na_differ;
    logic [DOT_W-1:0] nb_dot;

    vau_isqrt #(.IN_W(2 * NORM_W), .SIDE_IN_W(1)) u_norm_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s2_vld_reg),
        .radicand ({1'b0, sa_reg}),
        .side_in  (s2_differ_reg),
        .out_vld  (na_vld),
        .root     (na),
        .side_out (na_differ)
    );

    vau_isqrt #(.IN_W(2 * NORM_W), .SIDE_IN_W(DOT_W)) u_norm_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s2_vld_reg),
        .radicand ({1'b0, sb_reg}),
        .side_in  (dot2_reg),
        .out_vld  (nb_vld),
        .root     (nb),
        .side_out (nb_dot)
    );

    // ---- norm product, magnitude of dot
    logic              m_vld_reg;
    logic [DEN_W-1:0]  den_reg, mag_reg;
    item_side_t        m_side_reg;
    logic signed [DOT_W-1:0] dotn;
    logic [DOT_W-1:0]  absd;

    assign dotn = signed'(nb_dot);
    assign absd = dotn[DOT_W-1] ? DOT_W'(-dotn) : DOT_W'(dotn);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_vld_reg <= 1'b0;
        end
        else if (en) begin
            m_vld_reg <= na_vld & nb_vld;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            den_reg                <= DEN_W'(na * nb);
            mag_reg                <= absd[DEN_W-1:0];
            m_side_reg.dot         <= dotn;
            m_side_reg.norm_a      <= na;
            m_side_reg.norm_b      <= nb;
            m_side_reg.dims_differ <= na_differ;
            m_side_reg.zero_norm   <= (na == '0) || (nb == '0);
            m_side_reg.neg         <= dotn[DOT_W-1];
        end
    end

    // ---- cosine magnitude in Q2.30
    logic              d_vld;
    logic [QUO_W-1:0]  quo;
    item_side_t        d_side;

    vau_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (m_vld_reg),
        .mag      (mag_reg),
        .den      (den_reg),
        .side_in  (m_side_reg),
        .out_vld  (d_vld),
        .quo      (quo),
        .side_out (d_side)
    );

    logic             c_vld_reg, q_vld_reg, r_vld_reg;
    logic [COS_W-1:0] c_cos_reg, q_cos_reg, r_cos_reg;
    item_side_t       c_side_reg, q_side_reg, r_side_reg;
    logic [2*COS_W-1:0] q_sq_reg;
    logic [2*SIN_W-2:0] r_rad_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            c_vld_reg <= 1'b0;
            q_vld_reg <= 1'b0;
            r_vld_reg <= 1'b0;
        end
        else if (en) begin
            c_vld_reg <= d_vld;
            q_vld_reg <= c_vld_reg;
            r_vld_reg <= q_vld_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            c_cos_reg  <= (quo > QUO_W'(ONE_Q30)) ? ONE_Q30 : quo[COS_W-1:0];
            c_side_reg <= d_side;
            q_sq_reg   <= c_cos_reg * c_cos_reg;
            q_cos_reg  <= c_cos_reg;
            q_side_reg <= c_side_reg;
            r_rad_reg  <= {1'b1, 60'd0} - q_sq_reg[2*SIN_W-2:0];
            r_cos_reg  <= q_cos_reg;
            r_side_reg <= q_side_reg;
        end
    end

    // ---- sine
    localparam int SS_W = COS_W + SIDE_W;
    logic             s_vld;
    logic [SIN_W-1:0] sine;
    logic [SS_W-1:0]  s_side;

    vau_isqrt #(.IN_W(2 * SIN_W), .SIDE_IN_W(SS_W)) u_sine (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (r_vld_reg),
        .radicand ({1'b0, r_rad_reg}),
        .side_in  ({r_cos_reg, r_side_reg}),
        .out_vld  (s_vld),
        .root     (sine),
        .side_out (s_side)
    );

    // ---- angle
    localparam int CS_W = SIDE_W + 1;
    logic                     k_vld;
    logic signed [ZACC_W-1:0] z;
    logic [CS_W-1:0]          k_side;
    item_side_t               k_item;
    logic                     k_yzero;

    vau_cordic #(.SIDE_IN_W(CS_W)) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s_vld),
        .x_in     (signed'(CORDIC_W'(s_side[SS_W-1 -: COS_W]))),
        .y_in     (signed'(CORDIC_W'(sine))),
        .side_in  ({sine == '0, s_side[SIDE_W-1:0]}),
        .out_vld  (k_vld),
        .z_out    (z),
        .side_out (k_side)
    );

    assign k_yzero = k_side[CS_W-1];
    assign k_item  = item_side_t'(k_side[SIDE_W-1:0]);

    // ---- output register
    logic signed [THETA_W-1:0] zt, theta;
    logic [17:0]               rnd;
    logic [ANGLE_W-1:0]        angle_next;
    logic                      out_valid_reg;

    always_comb begin
        zt    = k_yzero ? '0 : THETA_W'(z);
        theta = k_item.neg ? signed'(DEG180_Q16) - zt : zt;
        rnd   = 18'((theta + THETA_W'(128)) >>> 8);
        if (k_item.dims_differ || k_item.zero_norm || theta[THETA_W-1]) begin
            angle_next = '0;
        end
        else if (rnd > ANGLE_MAX) begin
            angle_next = ANGLE_MAX[ANGLE_W-1:0];
        end
        else begin
            angle_next = rnd[ANGLE_W-1:0];
        end
    end

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (en) begin
            out_valid_reg <= k_vld;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            dot         <= k_item.dot;
            norm_a      <= k_item.norm_a;
            norm_b      <= k_item.norm_b;
            angle       <= angle_next;
            dims_differ <= k_item.dims_differ;
            zero_norm   <= k_item.zero_norm;
        end
    end

    assign out_valid = out_valid_reg;

    a_angle_masked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (dims_differ || zero_norm) |-> angle == '0)
        else $error("angle not zero on invalid item");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> angle <= ANGLE_MAX[ANGLE_W-1:0])
        else $error("angle out of range");

    a_dot_masked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dims_differ |-> dot == '0)
        else $error("dot not zero with differing dimensions");

    a_zero_norm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> zero_norm == ((norm_a == '0) || (norm_b == '0)))
        else $error("zero norm flag mismatch");

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        na_vld == nb_vld)
        else $error("norm pipelines out of step");
endmodule
`default_nettype wire

/* tb/angle_checker.sv */
`default_nettype none
module angle_checker import vau_pkg::*; (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic                      in_ready,
    input  wire logic [DIM_W-1:0]          dim_a,
    input  wire logic [DIM_W-1:0]          dim_b,
    input  wire logic signed [COORD_W-1:0] a_0,
    input  wire logic signed [COORD_W-1:0] a_1,
    input  wire logic signed [COORD_W-1:0] a_2,
    input  wire logic signed [COORD_W-1:0] a_3,
    input  wire logic signed [COORD_W-1:0] b_0,
    input  wire logic signed [COORD_W-1:0] b_1,
    input  wire logic signed [COORD_W-1:0] b_2,
    input  wire logic signed [COORD_W-1:0] b_3,
    input  wire logic                      out_valid,
    input  wire logic                      out_ready,
    input  wire logic signed [DOT_W-1:0]   dot,
    input  wire logic [NORM_W-1:0]         norm_a,
    input  wire logic [NORM_W-1:0]         norm_b,
    input  wire logic [ANGLE_W-1:0]        angle,
    input  wire logic                      dims_differ,
    input  wire logic                      zero_norm,
    output int                             errors,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic [NORM_W-1:0]       norm_a;
        logic [NORM_W-1:0]       norm_b;
        logic [ANGLE_W-1:0]      angle;
        logic                    dims_differ;
        logic                    zero_norm;
    } angle_result_t;

    angle_result_t expected_results[$];

    const longint ATAN_DEG[20] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
        58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint trunc_shift(input longint v, input int s);
        return v >= 0 ? longint'(v >>> s) : -((-v) >>> s);
    endfunction

    function automatic int unsigned fit_dim(input logic [DIM_W-1:0] d);
        if (d < 2) return 2;
        if (d > COORDS) return COORDS;
        return d;
    endfunction

    function automatic logic [ANGLE_W-1:0] angle_deg(input longint d,
        input longint unsigned na, input longint unsigned nb);
        longint unsigned mag, q;
        longint x, y, z, theta, xs, ys;
        mag = d < 0 ? -d : d;
        q = (mag << 30) / (na * nb);
        z = 0;
        if (q > (64'd1 << 30)) q = 64'd1 << 30;
        y = int_sqrt((64'd1 << 60) - q * q);
        x = q;
        if (y != 0) begin
            for (int i = 0; i < 20; i++) begin
                xs = trunc_shift(x, i);
                ys = trunc_shift(y, i);
                if (y >= 0) begin
                    x += ys; y -= xs; z += ATAN_DEG[i];
                end else begin
                    x -= ys; y += xs; z -= ATAN_DEG[i];
                end
            end
        end
        theta = d < 0 ? 180 * 65536 - z : z;
        if (theta < 0) return 0;
        theta = (theta + 128) >>> 8;
        if (theta > 46080) return 16'd46080;
        return theta[15:0];
    endfunction

    function automatic angle_result_t predict_angle();
        angle_result_t r;
        longint va[4], vb[4];
        longint unsigned sa, sb;
        longint d;
        int unsigned da, db;
        va = '{a_0, a_1, a_2, a_3};
        vb = '{b_0, b_1, b_2, b_3};
        da = fit_dim(dim_a);
        db = fit_dim(dim_b);
        sa = 0; sb = 0; d = 0;
        for (int i = 0; i < da; i++) sa += va[i] * va[i];
        for (int i = 0; i < db; i++) sb += vb[i] * vb[i];
        r.norm_a = int_sqrt(sa);
        r.norm_b = int_sqrt(sb);
        r.dims_differ = da != db;
        r.zero_norm = r.norm_a == 0 || r.norm_b == 0;
        r.angle = 0;
        if (!r.dims_differ) begin
            for (int i = 0; i < da; i++) d += va[i] * vb[i];
            if (!r.zero_norm) r.angle = angle_deg(d, r.norm_a, r.norm_b);
        end
        r.dot = d;
        return r;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n) begin
        angle_result_t e, got;
        if (!rst_n) begin
            errors <= 0;
        end else begin
            if (in_valid && in_ready) expected_results.push_back(predict_angle());
            if (out_valid && out_ready) begin
                got = '{dot, norm_a, norm_b, angle, dims_differ, zero_norm};
                if (expected_results.size() == 0) begin
                    $display("%t unexpected result %p", $realtime, got);
                    errors <= errors + 1;
                end else begin
                    e = expected_results.pop_front();
                    if (e !== got) begin
                        $display("%t mismatch expected %p actual %p", $realtime, e, got);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

/* tb/testbench.sv */
`default_nettype none
module testbench import vau_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 0, rst_n = 0;
    logic in_valid = 0, out_ready = 0;
    logic [DIM_W-1:0] dim_a = 2, dim_b = 2;
    logic signed [COORD_W-1:0] a_0 = 0, a_1 = 0, a_2 = 0, a_3 = 0;
    logic signed [COORD_W-1:0] b_0 = 0, b_1 = 0, b_2 = 0, b_3 = 0;
    wire logic in_ready, out_valid, dims_differ, zero_norm;
    wire logic signed [DOT_W-1:0] dot;
    wire logic [NORM_W-1:0] norm_a, norm_b;
    wire logic [ANGLE_W-1:0] angle;
    int errors, pending;
    int send_idle, recv_idle;

    always begin
        #4 clk = 1;
        #4 clk = 0;
    end

    vector_angle_unit u_dut (.*);
    angle_checker u_chk (.*);

    always @(posedge clk) out_ready <= $urandom_range(99) >= recv_idle;

    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 0;
            3: return $urandom_range(1024) - 512;
            default: return $urandom;
        endcase
    endfunction

    // valid stays high after a transfer until the next idle cycle or the next item
    task automatic send_pair(input logic [DIM_W-1:0] da, input logic [DIM_W-1:0] db,
        input logic signed [COORD_W-1:0] c[8]);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        dim_a <= da; dim_b <= db;
        {a_0, a_1, a_2, a_3} <= {c[0], c[1], c[2], c[3]};
        {b_0, b_1, b_2, b_3} <= {c[4], c[5], c[6], c[7]};
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_random();
        logic signed [COORD_W-1:0] c[8];
        logic [DIM_W-1:0] da, db;
        int mode;
        foreach (c[i]) c[i] = pick_coord();
        mode = $urandom_range(9);
        da = $urandom_range(2, 4);
        db = mode < 8 ? da : DIM_W'($urandom);
        if (mode == 9) da = $urandom;
        // parallel and antiparallel vectors hit the cosine clamp
        if (mode == 1) for (int i = 0; i < 4; i++) c[4 + i] = c[i];
        if (mode == 2) for (int i = 0; i < 4; i++) c[4 + i] = -c[i];
        if (mode == 3) for (int i = 0; i < 4; i++) c[i] = 0;
        send_pair(da, db, c);
    endtask

    initial begin
        logic signed [COORD_W-1:0] c[8];
        send_idle = 6; recv_idle = 88;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: extremes, out-of-range dims, zero norm, orthogonal, opposite
        c = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
              16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
        send_pair(4, 4, c);
        c = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
              16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
        send_pair(4, 4, c);
        c = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
              16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
        send_pair(7, 5, c);
        send_pair(0, 1, c);
        send_pair(1, 3, c);
        c = '{0, 0, 0, 0, 256, 0, 0, 0};
        send_pair(2, 2, c);
        send_pair(2, 3, c);
        c = '{256, 0, 0, 0, 0, 256, 0, 0};
        send_pair(2, 2, c);
        c = '{256, 256, 0, 0, -256, -256, 0, 0};
        send_pair(2, 2, c);
        c = '{1, 0, 0, 0, 1, 0, 0, 0};
        send_pair(3, 3, c);
        c = '{3, 4, 0, 0, -3, 4, 0, 0};
        send_pair(2, 2, c);
        c = '{100, -200, 300, 5, 7, 11, -13, 900};
        send_pair(4, 4, c);
        send_pair(3, 3, c);
        for (int i = 0; i < 1450; i++) begin
            if (i == 480) begin
                send_idle = 88; recv_idle = 6;
            end
            if (i == 960) begin
                send_idle = 0; recv_idle = 0;
            end
            if (i == 700) begin
                in_valid <= 0;
                @(posedge clk);
                wait (pending == 0);
            end
            send_random();
        end
        in_valid <= 0;
        @(posedge clk);
        wait (pending == 0);
        repeat (120) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #40ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

/* vector_angle_unit.f */
rtl/vau_pkg.sv
rtl/vau_isqrt.sv
rtl/vau_div.sv
rtl/vau_cordic.sv
rtl/vector_angle_unit.sv
tb/angle_checker.sv
tb/testbench.sv
